### hdl/tts_pkg.sv
package tts_pkg;
  localparam int NUM_SLOTS = 8;
  localparam int SW = $clog2(NUM_SLOTS);
  localparam int AW = $clog2(NUM_SLOTS + 1);
  localparam int QD = 2;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_DEL = 2'd1,
    CMD_TICK = 2'd2,
    CMD_DISP = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [2:0]  slot_to_delete;
    logic [15:0] task_tag;
    logic [31:0] first_delay;
    logic [31:0] repeat_period;
  } item_t;

  typedef struct packed {
    logic [AW-1:0] added_slot;
    logic          run_valid;
    logic [2:0]    run_slot;
    logic [15:0]   run_tag;
  } res_t;
endpackage

### hdl/tts_front.sv
module tts_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tts_pkg::item_t in_item,
  output logic          q_valid,
  input  logic          q_pop,
  output tts_pkg::item_t q_item
);
  import tts_pkg::*;

  localparam int PW = $clog2(QD);

  item_t           mem_r [QD];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            push;

  assign in_ready = (cnt_r != (PW+1)'(QD));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = q_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(QD)) else $error("queue overfilled");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !q_pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");
endmodule

### hdl/tts_back.sv
module tts_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  tts_pkg::item_t q_item,
  output logic           res_valid,
  input  logic           res_ready,
  output tts_pkg::res_t  res
);
  import tts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_MIN  = 4'b0100,
    S_OUT  = 4'b1000
  } st_t;

  st_t            st_r, st_nxt;
  logic [NUM_SLOTS-1:0] valid_r, ready_r;
  logic [15:0]    tag_r   [NUM_SLOTS];
  logic [31:0]    delay_r [NUM_SLOTS];
  logic [31:0]    period_r[NUM_SLOTS];
  logic [SW-1:0]  cur_r;
  logic [31:0]    elap_r;
  logic [SW:0]    idx_r;
  logic [SW-1:0]  best_r;
  logic [31:0]    bestd_r;
  logic           found_r;
  item_t          it_r;
  res_t           res_r;
  logic           rv_r;

  logic [SW-1:0]  ix;
  logic           last;
  logic           empty_found;
  logic [SW-1:0]  first_free;
  logic           disp_go;

  assign ix    = idx_r[SW-1:0];
  assign last  = (idx_r == (SW+1)'(NUM_SLOTS - 1));
  assign q_pop = (st_r == S_IDLE) && q_valid && !rv_r;
  assign res_valid = rv_r;
  assign res   = res_r;
  // keep walking once the release has cleared the ready flag
  assign disp_go = (it_r.command == CMD_DISP) && (ready_r[cur_r] || idx_r != '0);

  always_comb begin
    empty_found = 1'b0;
    first_free  = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (!valid_r[s]) begin
        empty_found = 1'b1;
        first_free  = SW'(s);
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_pop) st_nxt = S_WALK;
      S_WALK: if (disp_go) begin
        if (last) st_nxt = S_MIN;
      end else begin
        st_nxt = S_OUT;
      end
      S_MIN:  if (last) st_nxt = S_OUT;
      S_OUT:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      valid_r <= '0;
      ready_r <= '0;
      cur_r   <= '0;
      elap_r  <= '0;
      rv_r    <= 1'b0;
      idx_r   <= '0;
      found_r <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        tag_r[s]    <= '0;
        delay_r[s]  <= '0;
        period_r[s] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (rv_r && res_ready) rv_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_pop) begin
            it_r  <= q_item;
            idx_r <= '0;
            res_r <= '0;
          end
        end
        S_WALK: begin
          case (it_r.command)
            CMD_ADD: begin
              if (empty_found) begin
                valid_r[first_free]  <= 1'b1;
                ready_r[first_free]  <= 1'b0;
                tag_r[first_free]    <= it_r.task_tag;
                delay_r[first_free]  <= it_r.first_delay;
                period_r[first_free] <= it_r.repeat_period;
                res_r.added_slot     <= AW'(first_free);
              end else begin
                res_r.added_slot <= AW'(NUM_SLOTS);
              end
            end
            CMD_DEL: begin
              if (32'(it_r.slot_to_delete) < NUM_SLOTS) begin
                valid_r[SW'(it_r.slot_to_delete)]  <= 1'b0;
                ready_r[SW'(it_r.slot_to_delete)]  <= 1'b0;
                tag_r[SW'(it_r.slot_to_delete)]    <= '0;
                delay_r[SW'(it_r.slot_to_delete)]  <= '0;
                period_r[SW'(it_r.slot_to_delete)] <= '0;
              end
            end
            CMD_TICK: begin
              if (valid_r[cur_r]) begin
                if (delay_r[cur_r] == '0) begin
                  ready_r[cur_r] <= 1'b1;
                  if (period_r[cur_r] != '0) delay_r[cur_r] <= period_r[cur_r];
                end else begin
                  delay_r[cur_r] <= delay_r[cur_r] - 1'b1;
                  if (elap_r != '1) elap_r <= elap_r + 1'b1;
                end
              end
            end
            CMD_DISP: begin
              if (disp_go) begin
                if (idx_r == '0) begin
                  res_r.run_valid <= 1'b1;
                  res_r.run_slot  <= 3'(cur_r);
                  res_r.run_tag   <= tag_r[cur_r];
                  ready_r[cur_r]  <= 1'b0;
                  if (period_r[cur_r] == '0) begin
                    valid_r[cur_r]  <= 1'b0;
                    tag_r[cur_r]    <= '0;
                    delay_r[cur_r]  <= '0;
                    period_r[cur_r] <= '0;
                  end
                end
                if (valid_r[ix] && ix != cur_r) begin
                  delay_r[ix] <= (delay_r[ix] > elap_r) ? delay_r[ix] - elap_r : '0;
                end
                idx_r   <= last ? '0 : idx_r + 1'b1;
                found_r <= 1'b0;
                bestd_r <= '0;
                best_r  <= '0;
              end
            end
            default: ;
          endcase
        end
        S_MIN: begin
          if (valid_r[ix] && (!found_r || delay_r[ix] < bestd_r)) begin
            best_r  <= ix;
            bestd_r <= delay_r[ix];
            found_r <= 1'b1;
          end
          idx_r <= idx_r + 1'b1;
          if (last) begin
            if (valid_r[ix] && (!found_r || delay_r[ix] < bestd_r)) cur_r <= ix;
            else cur_r <= best_r;
            elap_r <= '0;
          end
        end
        S_OUT: rv_r <= 1'b1;
        default: ;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !rv_r) else $error("pop with result pending");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_OUT |=> rv_r) else $error("result not raised");
  a_run_full: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r && res_r.run_valid |-> res_r.added_slot == '0) else $error("mixed result");
endmodule

### hdl/tick_task_scheduler_table.sv
// Add, delete and tick pass through IDLE, WALK and OUT; a dispatch that releases
// a task also passes MIN (one pass in WALK to age slots, one in MIN to find the
// earliest). The back end works one word at a time, with a two-word queue in
// front so input can be taken while it works.
// Reset: synchronous active-low rst_n clears all slots, current slot and tick count.
module tick_task_scheduler_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [2:0]  in_slot_to_delete,
  input  logic [15:0] in_task_tag,
  input  logic [31:0] in_first_delay,
  input  logic [31:0] in_repeat_period,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_added_slot,
  output logic        out_run_valid,
  output logic [2:0]  out_run_slot,
  output logic [15:0] out_run_tag
);
  import tts_pkg::*;

  item_t in_item, q_item;
  res_t  res;
  logic  q_valid, q_pop;

  assign in_item.command        = cmd_t'(in_command);
  assign in_item.slot_to_delete = in_slot_to_delete;
  assign in_item.task_tag       = in_task_tag;
  assign in_item.first_delay    = in_first_delay;
  assign in_item.repeat_period  = in_repeat_period;

  tts_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_item,
    .q_valid, .q_pop, .q_item
  );

  tts_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item,
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign out_added_slot = 4'(res.added_slot);
  assign out_run_valid  = res.run_valid;
  assign out_run_slot   = res.run_slot;
  assign out_run_tag    = res.run_tag;
endmodule
